FILE: src/baro_temp_pressure_compensation_assert.svh
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensation_assert.svh
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef BARO_TEMP_PRESSURE_COMPENSATION_ASSERT_SVH
`define BARO_TEMP_PRESSURE_COMPENSATION_ASSERT_SVH

// same-cycle implication, reset masked
`define BTPC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, reset masked
`define BTPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication, checked during reset as well
`define BTPC_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/btpc_pkg.sv
// ----------------------------------------------------------------------------
// btpc_pkg
// shared types and constants of the barometric compensation pipeline
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package btpc_pkg;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_TEMP_CAL       = 2'd0,
    REG_PRESS_CAL_LOW  = 2'd1,
    REG_PRESS_CAL_HIGH = 2'd2,
    REG_PRESS_CAL_LAST = 2'd3
  } reg_idx_t;

  localparam int unsigned DIV_W   = 64;

  localparam logic signed [63:0] FINE_OFS   = 64'sd128000;
  localparam logic signed [63:0] P_FULL     = 64'sd1048576;
  localparam logic signed [63:0] P_SCALE    = 64'sd3125;
  localparam logic signed [63:0] V1_BIAS    = 64'sh0000_8000_0000_0000;
  localparam logic signed [31:0] T_ROUND    = 32'sd128;

  // request side data carried alongside the division
  typedef struct packed {
    logic signed [31:0] temp;
    logic               invalid;
  } side_t;

endpackage

FILE: src/btpc_front.sv
// ----------------------------------------------------------------------------
// btpc_front
// temperature compensation and pressure dividend/divisor, eight stages
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module btpc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                ce,
  input  logic                in_vld,
  input  logic [19:0]         raw_t,
  input  logic [19:0]         raw_p,
  input  logic [47:0]         temp_cal,
  input  logic [63:0]         press_lo,
  input  logic [63:0]         press_hi,
  output logic                out_vld,
  output logic signed [63:0]  num,
  output logic signed [63:0]  den,
  output logic signed [31:0]  temp
);

  logic [7:0] vld_r;

  // calibration words
  logic [31:0]        t1;
  logic signed [31:0] t2, t3;
  logic signed [63:0] p1, p2, p3, p4, p5, p6;
  assign t1 = {16'd0, temp_cal[15:0]};
  assign t2 = {{16{temp_cal[31]}}, temp_cal[31:16]};
  assign t3 = {{16{temp_cal[47]}}, temp_cal[47:32]};
  assign p1 = {48'd0, press_lo[15:0]};
  assign p2 = {{48{press_lo[31]}}, press_lo[31:16]};
  assign p3 = {{48{press_lo[47]}}, press_lo[47:32]};
  assign p4 = {{48{press_lo[63]}}, press_lo[63:48]};
  assign p5 = {{48{press_hi[15]}}, press_hi[15:0]};
  assign p6 = {{48{press_hi[31]}}, press_hi[31:16]};

  // stage registers
  logic signed [31:0] a1_r, dd1_r, va2_r, x2_r, temp3_r, temp4_r, temp5_r, temp6_r;
  logic signed [31:0] temp7_r, temp8_r;
  logic signed [63:0] v13_r, sq4_r, m54_r, m24_r, a65_r, a35_r, b5_r, c5_r;
  logic signed [63:0] v26_r, v1b6_r, v1c7_r, num7_r, num8_r, den8_r;
  logic [19:0]        rp1_r, rp2_r, rp3_r, rp4_r, rp5_r, rp6_r;

  // combinational terms per stage
  logic signed [31:0] a_nxt, d_nxt, dd_nxt, fine_nxt, temp_nxt;
  logic signed [63:0] fine64, num0;
  always_comb begin
    a_nxt    = ($signed({15'd0, raw_t[19:3]}) - $signed({t1[30:0], 1'b0})) * t2;
    d_nxt    = $signed({16'd0, raw_t[19:4]}) - $signed(t1);
    dd_nxt   = d_nxt * d_nxt;
    fine_nxt = va2_r + (x2_r >>> 14);
    temp_nxt = (fine_nxt + (fine_nxt <<< 2) + btpc_pkg::T_ROUND) >>> 8;
    fine64   = {{32{fine_nxt[31]}}, fine_nxt};
    num0     = ((btpc_pkg::P_FULL - $signed({44'd0, rp6_r})) <<< 31) - v26_r;
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ce) begin
      vld_r <= {vld_r[6:0], in_vld};
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (ce) begin
      // s1: first products of temperature
      a1_r   <= a_nxt;
      dd1_r  <= dd_nxt;
      rp1_r  <= raw_p;
      // s2: shifted terms
      va2_r  <= a1_r >>> 11;
      x2_r   <= (dd1_r >>> 12) * t3;
      rp2_r  <= rp1_r;
      // s3: fine temperature
      temp3_r <= temp_nxt;
      v13_r   <= fine64 - btpc_pkg::FINE_OFS;
      rp3_r   <= rp2_r;
      // s4: v1 products
      sq4_r   <= v13_r * v13_r;
      m54_r   <= v13_r * p5;
      m24_r   <= v13_r * p2;
      temp4_r <= temp3_r;
      rp4_r   <= rp3_r;
      // s5: calibration products
      a65_r   <= sq4_r * p6;
      a35_r   <= sq4_r * p3;
      b5_r    <= (m54_r <<< 17) + (p4 <<< 35);
      c5_r    <= m24_r <<< 12;
      temp5_r <= temp4_r;
      rp5_r   <= rp4_r;
      // s6: sums
      v26_r   <= a65_r + b5_r;
      v1b6_r  <= btpc_pkg::V1_BIAS + (a35_r >>> 8) + c5_r;
      temp6_r <= temp5_r;
      rp6_r   <= rp5_r;
      // s7: scale
      v1c7_r  <= v1b6_r * p1;
      num7_r  <= num0 * btpc_pkg::P_SCALE;
      temp7_r <= temp6_r;
      // s8: divisor
      den8_r  <= v1c7_r >>> 33;
      num8_r  <= num7_r;
      temp8_r <= temp7_r;
    end
  end

  assign out_vld = vld_r[7];
  assign num     = num8_r;
  assign den     = den8_r;
  assign temp    = temp8_r;

endmodule

FILE: src/btpc_div.sv
// ----------------------------------------------------------------------------
// btpc_div
// pipelined signed 64-bit divider, one quotient bit per stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module btpc_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                ce,
  input  logic                in_vld,
  input  logic signed [63:0]  num,
  input  logic signed [63:0]  den,
  input  btpc_pkg::side_t     side_in,
  output logic                out_vld,
  output logic signed [63:0]  quot,
  output btpc_pkg::side_t     side_out
);

  localparam int unsigned N = btpc_pkg::DIV_W;

  logic [N:0]       vld_r;
  logic [63:0]      rem_r  [N+1];
  logic [63:0]      n_r    [N+1];
  logic [63:0]      d_r    [N+1];
  logic [N:0]       neg_r;
  btpc_pkg::side_t  side_r [N+1];
  logic             vout_r;
  logic signed [63:0] quot_r;
  btpc_pkg::side_t  sout_r;

  // entry: magnitudes and sign
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (ce) begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      rem_r[0]  <= '0;
      n_r[0]    <= num[63] ? 64'(-num) : 64'(num);
      d_r[0]    <= den[63] ? 64'(-den) : 64'(den);
      neg_r[0]  <= num[63] ^ den[63];
      side_r[0] <= '{temp: side_in.temp, invalid: (den == 64'sd0)};
    end
  end

  // restoring steps
  for (genvar k = 0; k < N; k++) begin : g_step
    logic [63:0] sh;
    logic        ge;
    always_comb begin
      sh = {rem_r[k][62:0], n_r[k][63]};
      ge = (sh >= d_r[k]);
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (ce) begin
        vld_r[k+1] <= vld_r[k];
      end
    end
    always_ff @(posedge clk) begin
      if (ce) begin
        rem_r[k+1]  <= ge ? (sh - d_r[k]) : sh;
        n_r[k+1]    <= {n_r[k][62:0], ge};
        d_r[k+1]    <= d_r[k];
        neg_r[k+1]  <= neg_r[k];
        side_r[k+1] <= side_r[k];
      end
    end
  end

  // exit: apply sign
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vout_r <= 1'b0;
    end else if (ce) begin
      vout_r <= vld_r[N];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      quot_r <= neg_r[N] ? $signed(64'(-n_r[N])) : $signed(n_r[N]);
      sout_r <= side_r[N];
    end
  end

  assign out_vld  = vout_r;
  assign quot     = quot_r;
  assign side_out = sout_r;

endmodule

FILE: src/btpc_back.sv
// ----------------------------------------------------------------------------
// btpc_back
// pressure correction terms and output register, four stages
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module btpc_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                ce,
  input  logic                in_vld,
  input  logic signed [63:0]  p_in,
  input  btpc_pkg::side_t     side_in,
  input  logic [63:0]         press_hi,
  input  logic [15:0]         press_last,
  output logic                out_vld,
  output logic signed [31:0]  temp,
  output logic [31:0]         press,
  output logic                invalid
);

  logic signed [63:0] p7, p8, p9;
  assign p7 = {{48{press_hi[47]}}, press_hi[47:32]};
  assign p8 = {{48{press_hi[63]}}, press_hi[63:48]};
  assign p9 = {{48{press_last[15]}}, press_last};

  // halves of p/8192 for the split square
  logic [31:0] al, ah;
  assign al = p_in[44:13];
  assign ah = {{13{p_in[63]}}, p_in[63:45]};

  logic [3:0] vld_r;
  logic signed [63:0] p1_r, m81_r, p2_r, sq2_r, w22_r, p3_r, m93_r, w23_r;
  logic [63:0]        lo1_r;
  logic [31:0]        cr1_r;
  btpc_pkg::side_t    s1_r, s2_r, s3_r;
  logic signed [31:0] temp_r;
  logic [31:0]        press_r;
  logic               inv_r;
  logic signed [63:0] pf;

  // final sum
  assign pf = ((p3_r + (m93_r >>> 25) + w23_r) >>> 8) + (p7 <<< 4);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ce) begin
      vld_r <= {vld_r[2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      // b1: partial products of (p/8192)^2 and p8 product
      p1_r  <= p_in;
      lo1_r <= 64'(al) * 64'(al);
      cr1_r <= al * ah;
      m81_r <= p8 * p_in;
      s1_r  <= side_in;
      // b2: square, low 64 bits
      p2_r  <= p1_r;
      sq2_r <= $signed(lo1_r + {cr1_r[30:0], 33'd0});
      w22_r <= m81_r >>> 19;
      s2_r  <= s1_r;
      // b3: p9 product
      p3_r  <= p2_r;
      m93_r <= p9 * sq2_r;
      w23_r <= w22_r;
      s3_r  <= s2_r;
      // b4: output register
      temp_r  <= s3_r.temp;
      press_r <= s3_r.invalid ? 32'd0 : pf[31:0];
      inv_r   <= s3_r.invalid;
    end
  end

  assign out_vld = vld_r[3];
  assign temp    = temp_r;
  assign press   = press_r;
  assign invalid = inv_r;

endmodule

FILE: src/baro_temp_pressure_compensation.sv
// pipeline: front, divider and back sections between input request and result
// throughput: one request per cycle; the whole pipeline holds while the result stalls
// the 64-step restoring divider sets the depth, one quotient bit per stage
// reset: synchronous active-low rst_n clears valid bits and calibration registers
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensation
// top level: calibration registers and the compensation pipeline
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module baro_temp_pressure_compensation (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [63:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // raw_temperature[19:0], raw_pressure[39:20]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata   // temperature_centi[31:0], pressure_q24_8[63:32],
                                  // pressure_invalid[64], zero [71:65]
);

  logic [47:0] temp_cal_r;
  logic [63:0] press_lo_r, press_hi_r;
  logic [15:0] press_last_r;
  logic        ce;

  // calibration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_cal_r   <= '0;
      press_lo_r   <= '0;
      press_hi_r   <= '0;
      press_last_r <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        btpc_pkg::REG_TEMP_CAL:       temp_cal_r   <= cfg_wdata[47:0];
        btpc_pkg::REG_PRESS_CAL_LOW:  press_lo_r   <= cfg_wdata;
        btpc_pkg::REG_PRESS_CAL_HIGH: press_hi_r   <= cfg_wdata;
        btpc_pkg::REG_PRESS_CAL_LAST: press_last_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // global advance
  assign ce        = !out_tvalid || out_tready;
  assign in_tready = ce;

  logic               f_vld, d_vld;
  logic signed [63:0] f_num, f_den, d_quot;
  logic signed [31:0] f_temp, o_temp;
  btpc_pkg::side_t    f_side, d_side;
  logic [31:0]        o_press;
  logic               o_inv;

  assign f_side = '{temp: f_temp, invalid: 1'b0};

  btpc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .ce       (ce),
    .in_vld   (in_tvalid),
    .raw_t    (in_tdata[19:0]),
    .raw_p    (in_tdata[39:20]),
    .temp_cal (temp_cal_r),
    .press_lo (press_lo_r),
    .press_hi (press_hi_r),
    .out_vld  (f_vld),
    .num      (f_num),
    .den      (f_den),
    .temp     (f_temp)
  );

  btpc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ce       (ce),
    .in_vld   (f_vld),
    .num      (f_num),
    .den      (f_den),
    .side_in  (f_side),
    .out_vld  (d_vld),
    .quot     (d_quot),
    .side_out (d_side)
  );

  btpc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .ce         (ce),
    .in_vld     (d_vld),
    .p_in       (d_quot),
    .side_in    (d_side),
    .press_hi   (press_hi_r),
    .press_last (press_last_r),
    .out_vld    (out_tvalid),
    .temp       (o_temp),
    .press      (o_press),
    .invalid    (o_inv)
  );

  assign out_tdata = {7'd0, o_inv, o_press, o_temp};

endmodule

FILE: src/btpc_checker.sv
// ----------------------------------------------------------------------------
// btpc_checker
// port-level checks of the compensation block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "baro_temp_pressure_compensation_assert.svh"

module btpc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata
);

  // flagged results carry zero pressure
  `BTPC_ASSERT_NOW(a_inv_zero, out_tvalid && out_tdata[64], out_tdata[63:32] == 32'd0, "invalid pressure not zero")

  // a stalled result stays valid
  `BTPC_ASSERT_NEXT(a_hold, out_tvalid && !out_tready, out_tvalid, "result dropped under stall")

  // input side follows output backpressure
  `BTPC_ASSERT_NOW(a_ready, out_tvalid && !out_tready, !in_tready, "request taken while result stalled")

  // nothing comes out right after reset
  `BTPC_ASSERT_RST(a_reset, !rst_n, !out_tvalid, "result valid after reset")

endmodule

bind baro_temp_pressure_compensation btpc_checker u_btpc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

FILE: bench/baro_temp_pressure_compensation_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensation_tb
// drives raw sample pairs under several calibration sets, predicts the
// compensated temperature and pressure, and checks every result in order
// ----------------------------------------------------------------------------

module baro_temp_pressure_compensation_tb;

  typedef struct packed {
    logic [19:0] raw_p;
    logic [19:0] raw_t;
  } sample_t;

  typedef struct packed {
    logic        press_invalid;
    logic [31:0] press_q24_8;
    logic [31:0] temp_centi;
  } comp_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = '0;
  logic [63:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;

  // calibration copy held by the predictor
  logic [47:0] cal_t;
  logic [63:0] cal_pl, cal_ph;
  logic [15:0] cal_p9;

  sample_t pending_q[$];
  comp_t   comp_q[$];
  int      mismatches = 0;
  bit      calm = 1'b0;
  bit      hold_send = 1'b0;

  baro_temp_pressure_compensation dut (.*);

  always #10 clk = ~clk;

  function automatic logic signed [63:0] quot_trunc(logic signed [63:0] n,
                                                    logic signed [63:0] d);
    logic [63:0] mn, md, q;
    mn = n[63] ? -n : n;
    md = d[63] ? -d : d;
    q = mn / md;
    return (n[63] != d[63]) ? -q : q;
  endfunction

  function automatic comp_t compensate(sample_t s);
    comp_t r;
    logic signed [31:0] t1, t2, t3, a, d, fine, va, vb;
    logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic signed [63:0] v1, v2, p, ps, w1, w2;
    t1 = {16'd0, cal_t[15:0]};
    t2 = {{16{cal_t[31]}}, cal_t[31:16]};
    t3 = {{16{cal_t[47]}}, cal_t[47:32]};
    a = ($signed({12'd0, s.raw_t >> 3}) - (t1 <<< 1)) * t2;
    va = a >>> 11;
    d = $signed({12'd0, s.raw_t >> 4}) - t1;
    vb = (((d * d) >>> 12) * t3) >>> 14;
    fine = va + vb;
    r.temp_centi = (fine * 5 + btpc_pkg::T_ROUND) >>> 8;
    p1 = {48'd0, cal_pl[15:0]};
    p2 = {{48{cal_pl[31]}}, cal_pl[31:16]};
    p3 = {{48{cal_pl[47]}}, cal_pl[47:32]};
    p4 = {{48{cal_pl[63]}}, cal_pl[63:48]};
    p5 = {{48{cal_ph[15]}}, cal_ph[15:0]};
    p6 = {{48{cal_ph[31]}}, cal_ph[31:16]};
    p7 = {{48{cal_ph[47]}}, cal_ph[47:32]};
    p8 = {{48{cal_ph[63]}}, cal_ph[63:48]};
    p9 = {{48{cal_p9[15]}}, cal_p9};
    v1 = {{32{fine[31]}}, fine} - btpc_pkg::FINE_OFS;
    v2 = v1 * v1 * p6;
    v2 = v2 + ((v1 * p5) <<< 17);
    v2 = v2 + (p4 <<< 35);
    v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
    v1 = ((btpc_pkg::V1_BIAS + v1) * p1) >>> 33;
    if (v1 == 0) begin
      r.press_q24_8 = '0;
      r.press_invalid = 1'b1;
    end else begin
      p = btpc_pkg::P_FULL - $signed({44'd0, s.raw_p});
      p = quot_trunc(((p <<< 31) - v2) * btpc_pkg::P_SCALE, v1);
      ps = p >>> 13;
      w1 = (p9 * ps * ps) >>> 25;
      w2 = (p8 * p) >>> 19;
      p = ((p + w1 + w2) >>> 8) + (p7 <<< 4);
      r.press_q24_8 = p[31:0];
      r.press_invalid = 1'b0;
    end
    return r;
  endfunction

  // driver: one request per handshake, random gaps, held while waiting
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        comp_q.push_back(compensate(in_tdata));
        void'(pending_q.pop_front());
      end
      if (in_tvalid && !in_tready) begin
        // waiting request stays on the bus
      end else if (pending_q.size() > 0 && !hold_send &&
                   (calm || $urandom_range(99) >= 32)) begin
        in_tvalid <= 1'b1;
        in_tdata  <= pending_q[0];
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // monitor: compare each result with the oldest prediction
  always @(posedge clk) begin
    comp_t got, want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[64:0];
        if (comp_q.size() == 0 || out_tdata[71:65] != 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", out_tdata);
        end else begin
          want = comp_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected t=%h p=%h inv=%b got t=%h p=%h inv=%b",
                       want.temp_centi, want.press_q24_8, want.press_invalid,
                       got.temp_centi, got.press_q24_8, got.press_invalid);
          end
        end
      end
      out_tready <= calm || $urandom_range(99) >= 32;
    end
  end

  task automatic write_reg(btpc_pkg::reg_idx_t idx, logic [63:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      btpc_pkg::REG_TEMP_CAL:       cal_t = val[47:0];
      btpc_pkg::REG_PRESS_CAL_LOW:  cal_pl = val;
      btpc_pkg::REG_PRESS_CAL_HIGH: cal_ph = val;
      default:                      cal_p9 = val[15:0];
    endcase
  endtask

  task automatic drain;
    wait (pending_q.size() == 0 && !in_tvalid);
    wait (comp_q.size() == 0);
    repeat (100) @(posedge clk);
  endtask

  // typical calibration with small random spread
  task automatic set_typical;
    write_reg(btpc_pkg::REG_TEMP_CAL, 64'({16'($urandom_range(40) - 20 + 50),
                                           16'(26435 + $urandom_range(200)),
                                           16'(27504 + $urandom_range(200))}));
    write_reg(btpc_pkg::REG_PRESS_CAL_LOW,
              {16'd2855, -16'sd2000 - 16'($urandom_range(100)),
               -16'sd10685, 16'(36477 + $urandom_range(300))});
    write_reg(btpc_pkg::REG_PRESS_CAL_HIGH, {-16'sd7000, 16'd15500, -16'sd7, 16'd140});
    write_reg(btpc_pkg::REG_PRESS_CAL_LAST, 64'(16'd6000 + 16'($urandom_range(100))));
  endtask

  task automatic push(logic [19:0] t, logic [19:0] p);
    sample_t s;
    s.raw_t = t;
    s.raw_p = p;
    pending_q.push_back(s);
  endtask

  initial begin
    cal_t = '0; cal_pl = '0; cal_ph = '0; cal_p9 = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    // reset calibration: divisor is zero, pressure flagged invalid
    push(20'd0, 20'd0);
    push(20'hFFFFF, 20'hFFFFF);
    drain();
    set_typical();
    push(20'd519888, 20'd415148);
    push(20'd0, 20'hFFFFF);
    push(20'hFFFFF, 20'd0);
    push(20'd0, 20'd0);
    push(20'hFFFFF, 20'hFFFFF);
    push(20'h55555, 20'hAAAAA);
    push(20'hAAAAA, 20'h55555);
    drain();
    // extreme calibration words
    write_reg(btpc_pkg::REG_TEMP_CAL, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(btpc_pkg::REG_PRESS_CAL_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(btpc_pkg::REG_PRESS_CAL_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(btpc_pkg::REG_PRESS_CAL_LAST, 64'hFFFF_FFFF_FFFF_FFFF);
    push(20'd0, 20'd0);
    push(20'hFFFFF, 20'hFFFFF);
    push(20'h12345, 20'h6789A);
    drain();
    write_reg(btpc_pkg::REG_TEMP_CAL, 64'h0000_8000_8000_0000);
    write_reg(btpc_pkg::REG_PRESS_CAL_LOW, 64'h8000_8000_8000_FFFF);
    write_reg(btpc_pkg::REG_PRESS_CAL_HIGH, 64'h7FFF_8000_7FFF_8000);
    write_reg(btpc_pkg::REG_PRESS_CAL_LAST, 64'h0000_0000_0000_8000);
    push(20'd0, 20'hFFFFF);
    push(20'hFFFFF, 20'd0);
    push(20'h80000, 20'h80000);
    drain();
    // random phases: mostly realistic calibration, some fully random
    for (int ph = 0; ph < 8; ph++) begin
      if (ph % 3 == 2) begin
        write_reg(btpc_pkg::REG_TEMP_CAL, {$urandom, $urandom});
        write_reg(btpc_pkg::REG_PRESS_CAL_LOW, {$urandom, $urandom});
        write_reg(btpc_pkg::REG_PRESS_CAL_HIGH, {$urandom, $urandom});
        write_reg(btpc_pkg::REG_PRESS_CAL_LAST, {$urandom, $urandom});
      end else begin
        set_typical();
      end
      calm = (ph == 4);
      for (int i = 0; i < 100; i++) begin
        if ($urandom_range(3) == 0)
          push(20'($urandom), 20'($urandom));
        else
          push(20'(480000 + $urandom_range(80000)), 20'(250000 + $urandom_range(300000)));
      end
      if (ph == 1) begin
        // hold the sender until the pipeline is empty
        wait (pending_q.size() < 50);
        hold_send = 1'b1;
        wait (comp_q.size() == 0 && !in_tvalid);
        hold_send = 1'b0;
      end
      drain();
    end
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

endmodule

FILE: files.f
+incdir+src
src/btpc_pkg.sv
src/btpc_front.sv
src/btpc_div.sv
src/btpc_back.sv
src/baro_temp_pressure_compensation.sv
src/btpc_checker.sv
bench/baro_temp_pressure_compensation_tb.sv
